// File: design/ftsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftsm_pkg
// Shared constants and types for the floppy track sector mark scanner.
// ----------------------------------------------------------------------------
package ftsm_pkg;

    localparam int TRACK_BYTES_DEFAULT = 8192;
    localparam int MAX_SECTORS_PER_TRACK = 32;

    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 6;
    localparam int OFFSET_W = 13;
    localparam int SKIP_W   = 15;
    localparam int STEP_W   = 3;
    localparam int SIZE_W   = 3;
    localparam int TDATA_W  = 72;

    localparam logic [BYTE_W-1:0] ID_MARK      = 8'hFE;
    localparam logic [BYTE_W-1:0] DATA_MARK    = 8'hFB;
    localparam logic [BYTE_W-1:0] DELETED_MARK = 8'hF8;

    localparam logic [SIZE_W-1:0] MAX_SIZE_CODE = 3'd7;
    localparam logic [SKIP_W-1:0] ID_FIELD_SKIP = 15'd6;
    localparam logic [SKIP_W-1:0] CRC_BYTES     = 15'd2;
    localparam logic [SKIP_W-1:0] BASE_SECTOR   = 15'd128;

    localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_FIRST = 3'd1;
    localparam logic [STEP_W-1:0] STEP_LAST  = 3'd4;

    localparam logic KIND_SECTOR  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // One queue entry: everything one track byte asks the back end to emit.
    typedef struct packed {
        logic                has_sector;
        logic                has_summary;
        logic [COUNT_W-1:0]  sector_index;
        logic [COUNT_W-1:0]  summary_count;
        logic [BYTE_W-1:0]   cylinder;
        logic [BYTE_W-1:0]   head;
        logic [BYTE_W-1:0]   record_number;
        logic [BYTE_W-1:0]   size_code;
        logic [OFFSET_W-1:0] id_offset;
        logic [OFFSET_W-1:0] data_offset;
        logic                deleted;
        logic                sector_overflow;
        logic                summary_overflow;
    } q_entry_t;

endpackage

// File: design/ftsm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftsm_front
// Scans track bytes for ID and data marks and posts records to the queue.
// ----------------------------------------------------------------------------
module ftsm_front #(
    parameter int TRACK_BYTES = ftsm_pkg::TRACK_BYTES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          byte_valid,
    output logic                          byte_ready,
    input  logic [ftsm_pkg::BYTE_W-1:0]   track_byte,
    input  logic                          last_of_track,
    output logic                          push_valid,
    input  logic                          push_ready,
    output ftsm_pkg::q_entry_t            push_entry
);

    localparam int POS_W = $clog2(TRACK_BYTES);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(TRACK_BYTES - 1);
    localparam logic [ftsm_pkg::COUNT_W-1:0] SECTOR_LIMIT =
        ftsm_pkg::COUNT_W'(ftsm_pkg::MAX_SECTORS_PER_TRACK);

    logic                           hunting_reg, hunting_next;
    logic [ftsm_pkg::SKIP_W-1:0]    skip_reg, skip_next;
    logic [POS_W-1:0]               pos_reg, pos_next;
    logic [ftsm_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [ftsm_pkg::BYTE_W-1:0]    id_reg [4];
    logic [ftsm_pkg::BYTE_W-1:0]    id_next [4];
    logic [POS_W-1:0]               held_reg, held_next;
    logic [ftsm_pkg::COUNT_W-1:0]   sectors_reg, sectors_next;
    logic                           ovf_reg, ovf_next;

    logic                           accept;
    logic                           found_sector;
    logic                           ovf_mark;
    logic [ftsm_pkg::SIZE_W-1:0]    size_eff;
    logic [1:0]                     capture_idx;

    assign byte_ready = push_ready;
    assign accept     = byte_valid && push_ready;
    assign push_valid = accept && (found_sector || last_of_track);
    assign capture_idx = 2'(step_reg - ftsm_pkg::STEP_FIRST);
    assign size_eff = (id_reg[3] > 8'(ftsm_pkg::MAX_SIZE_CODE)) ? ftsm_pkg::MAX_SIZE_CODE
                                                               : id_reg[3][2:0];

    always_comb
    begin
        hunting_next = hunting_reg;
        skip_next    = skip_reg;
        step_next    = step_reg;
        id_next      = id_reg;
        held_next    = held_reg;
        sectors_next = sectors_reg;
        ovf_mark     = ovf_reg;
        found_sector = 1'b0;

        if (skip_reg != '0)
        begin
            skip_next = skip_reg - 15'd1;
            if (step_reg >= ftsm_pkg::STEP_FIRST && step_reg <= ftsm_pkg::STEP_LAST)
            begin
                id_next[capture_idx] = track_byte;
                step_next = (step_reg == ftsm_pkg::STEP_LAST) ? ftsm_pkg::STEP_IDLE
                                                              : step_reg + 3'd1;
            end
        end
        else if (!hunting_reg)
        begin
            if (track_byte == ftsm_pkg::ID_MARK)
            begin
                held_next = pos_reg;
                if (sectors_reg < SECTOR_LIMIT)
                    sectors_next = sectors_reg + 6'd1;
                else
                    ovf_mark = 1'b1;
                step_next    = ftsm_pkg::STEP_FIRST;
                skip_next    = ftsm_pkg::ID_FIELD_SKIP;
                hunting_next = 1'b1;
            end
        end
        else if (track_byte == ftsm_pkg::DATA_MARK || track_byte == ftsm_pkg::DELETED_MARK)
        begin
            found_sector = 1'b1;
            skip_next    = (ftsm_pkg::BASE_SECTOR << size_eff) + ftsm_pkg::CRC_BYTES;
            hunting_next = 1'b0;
        end

        ovf_next = ovf_mark;
        pos_next = pos_reg;
        if (last_of_track)
        begin
            // The track is finished: every piece of scan state rearms.
            hunting_next = 1'b0;
            skip_next    = '0;
            pos_next     = '0;
            step_next    = ftsm_pkg::STEP_IDLE;
            for (int i = 0; i < 4; i++)
                id_next[i] = '0;
            held_next    = '0;
            sectors_next = '0;
            ovf_next     = 1'b0;
        end
        else if (pos_reg < POS_MAX)
            pos_next = pos_reg + POS_W'(1);
        else
            ovf_next = 1'b1;
    end

    always_comb
    begin
        push_entry.has_sector       = found_sector;
        push_entry.has_summary      = last_of_track;
        push_entry.sector_index     = (sectors_reg != '0) ? sectors_reg - 6'd1 : '0;
        push_entry.summary_count    = (last_of_track) ? 6'(sectors_reg + 6'(ovf_mark & 1'b0))
                                                      : sectors_reg;
        push_entry.cylinder         = id_reg[0];
        push_entry.head             = id_reg[1];
        push_entry.record_number    = id_reg[2];
        push_entry.size_code        = id_reg[3];
        push_entry.id_offset        = ftsm_pkg::OFFSET_W'(held_reg);
        push_entry.data_offset      = ftsm_pkg::OFFSET_W'(pos_reg);
        push_entry.deleted          = (track_byte == ftsm_pkg::DELETED_MARK);
        push_entry.sector_overflow  = ovf_reg;
        push_entry.summary_overflow = ovf_mark;
        // The count after this byte's own ID mark, if it carried one.
        if (skip_reg == '0 && !hunting_reg && track_byte == ftsm_pkg::ID_MARK
            && sectors_reg < SECTOR_LIMIT)
            push_entry.summary_count = sectors_reg + 6'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunting_reg <= 1'b0;
            skip_reg    <= '0;
            pos_reg     <= '0;
            step_reg    <= ftsm_pkg::STEP_IDLE;
            for (int i = 0; i < 4; i++)
                id_reg[i] <= '0;
            held_reg    <= '0;
            sectors_reg <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (accept)
        begin
            hunting_reg <= hunting_next;
            skip_reg    <= skip_next;
            pos_reg     <= pos_next;
            step_reg    <= step_next;
            id_reg      <= id_next;
            held_reg    <= held_next;
            sectors_reg <= sectors_next;
            ovf_reg     <= ovf_next;
        end
    end

endmodule

// File: design/ftsm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftsm_queue
// Two-entry record queue between the scanner and the output sequencer.
// ----------------------------------------------------------------------------
module ftsm_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  ftsm_pkg::q_entry_t push_entry,
    output logic               pop_valid,
    input  logic               pop_ready,
    output ftsm_pkg::q_entry_t pop_entry
);

    ftsm_pkg::q_entry_t entry_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_entry  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// File: design/ftsm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftsm_back
// Turns each queued entry into one or two output records.
// ----------------------------------------------------------------------------
module ftsm_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  ftsm_pkg::q_entry_t             pop_entry,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ftsm_pkg::TDATA_W-1:0]   out_data,
    output logic                           out_kind,
    output logic                           out_last
);

    // Set once the sector record of a two-record entry has gone out.
    logic phase_reg, phase_next;
    logic show_sector;
    logic take;

    assign show_sector = pop_entry.has_sector && !phase_reg;
    assign out_valid   = pop_valid;
    assign out_kind    = show_sector ? ftsm_pkg::KIND_SECTOR : ftsm_pkg::KIND_SUMMARY;
    assign out_last    = !show_sector || !pop_entry.has_summary;
    assign take        = out_valid && out_ready;
    assign pop_ready   = out_ready && out_last;

    always_comb
    begin
        if (show_sector)
            out_data = {6'd0,
                        pop_entry.sector_overflow,
                        pop_entry.deleted,
                        pop_entry.data_offset,
                        pop_entry.id_offset,
                        pop_entry.size_code,
                        pop_entry.record_number,
                        pop_entry.head,
                        pop_entry.cylinder,
                        pop_entry.sector_index};
        else
            out_data = {6'd0,
                        pop_entry.summary_overflow,
                        59'd0,
                        pop_entry.summary_count};
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (take)
            phase_next = !out_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= 1'b0;
        else
            phase_reg <= phase_next;
    end

endmodule

// File: design/floppy_track_sector_mark_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// floppy_track_sector_mark_scanner
// Scans a raw track byte stream for ID and data address marks and reports
// one record per sector found plus a summary at the end of each track.
//
//   Channel   Dir  Payload                                  Marker
//   s_axis    in   tdata[7:0] track_byte                    tlast last_of_track
//   m_axis    out  tdata: sector fields, see port comment    tuser record_kind,
//                                                           tlast last
//
// One track byte is taken every cycle; the scanner updates its state in the
// same cycle. Records pass through a two-entry queue to the output sequencer,
// which sends one record per cycle while m_axis_tready is high; a byte ending a
// sector and the track yields two records. The scanner stalls only when the
// queue is full. Asynchronous reset clears all scan state; no clearing pass.
// ----------------------------------------------------------------------------
module floppy_track_sector_mark_scanner #(
    parameter int TRACK_BYTES = ftsm_pkg::TRACK_BYTES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] track_byte
    input  logic [7:0]                    s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [5:0] sector_index, [13:6] cylinder, [21:14] head, [29:22] record_number,
    // [37:30] size_code, [50:38] id_offset, [63:51] data_offset, [64] deleted,
    // [65] overflow, [71:66] zero
    output logic [ftsm_pkg::TDATA_W-1:0]  m_axis_tdata,
    // [0] record_kind
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast
);

    logic               push_valid, push_ready;
    ftsm_pkg::q_entry_t push_entry;
    logic               pop_valid, pop_ready;
    ftsm_pkg::q_entry_t pop_entry;

    ftsm_front #(
        .TRACK_BYTES (TRACK_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (s_axis_tvalid),
        .byte_ready    (s_axis_tready),
        .track_byte    (s_axis_tdata),
        .last_of_track (s_axis_tlast),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_entry    (push_entry)
    );

    ftsm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    ftsm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_kind  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

// File: design/ftsm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftsm_checker
// Port-level checks on the record stream of the sector mark scanner.
// ----------------------------------------------------------------------------
module ftsm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [ftsm_pkg::TDATA_W-1:0]  m_axis_tdata,
    input logic                          m_axis_tuser,
    input logic                          m_axis_tlast
);

    // A stalled record holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output record changed while stalled");

    // A summary always closes the records of its byte.
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ftsm_pkg::KIND_SUMMARY |-> m_axis_tlast)
        else $error("summary record without tlast");

    // A summary carries only the count and the overflow flag.
    a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ftsm_pkg::KIND_SUMMARY |->
            m_axis_tdata[64:6] == '0 && m_axis_tdata[71:66] == '0)
        else $error("summary record has sector fields set");

    // A sector record that is not last is followed at once by its summary.
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser == ftsm_pkg::KIND_SECTOR
            && !m_axis_tlast |=> m_axis_tvalid && m_axis_tuser == ftsm_pkg::KIND_SUMMARY)
        else $error("sector record not followed by its summary");

endmodule

bind floppy_track_sector_mark_scanner ftsm_checker u_ftsm_checker (.*);
